FILE: src/stog_pkg.sv
// shared widths and register index codes for the spiral tile order generator
`default_nettype none

package stog_pkg;

    localparam int COORD_W    = 21;
    localparam int SIZE_W     = 12;
    localparam int ORIGIN_W   = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_TILE_SIZE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LAST_ROW  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LAST_COL  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y  = 3'd4;

    localparam logic [SIZE_W-1:0] TILE_SIZE_RESET = 12'd16;
    localparam int                LAST_ROW_RESET  = 14;
    localparam int                LAST_COL_RESET  = 19;

endpackage

`default_nettype wire

FILE: src/stog_rect.sv
// tile index to pixel span: index * tile size + origin, and the far edge
`default_nettype none

module stog_rect #(
    parameter int IDX_W = 8
) (
    input  wire logic [IDX_W-1:0]                idx,
    input  wire logic [stog_pkg::SIZE_W-1:0]     tile_size,
    input  wire logic [stog_pkg::ORIGIN_W-1:0]   origin,
    output logic      [stog_pkg::COORD_W-1:0]    lo,
    output logic      [stog_pkg::COORD_W-1:0]    hi
);

    localparam int PROD_W = IDX_W + stog_pkg::SIZE_W;

    logic [PROD_W-1:0] product;

    assign product = PROD_W'(idx) * PROD_W'(tile_size);

    // coordinates wrap modulo the output width
    assign lo = stog_pkg::COORD_W'(product) + stog_pkg::COORD_W'(origin);
    assign hi = lo + stog_pkg::COORD_W'(tile_size);

endmodule

`default_nettype wire

FILE: src/spiral_tile_order_generator.sv
// Spiral tile order generator: walks a grid of last_row+1 by last_col+1 tiles in
// counter-clockwise spiral order from the top-left tile, first heading down. Each
// input beat with restart high reloads the bounds from the registers and yields the
// first tile; each beat with restart low yields the next tile, or nothing once the
// tile flagged last_tile has gone out. One beat is taken every clock cycle while the
// output is not stalled: walk state, tile-to-pixel multiply-add and output
// register all update in the same cycle, and the output register lets a new beat in
// while its result is being taken. The user must see that registers are written only
// while no beat is in flight; the block itself does not enforce this.
`default_nettype none

module spiral_tile_order_generator #(
    parameter int TILE_INDEX_BITS = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               cfg_wr_en,
    input  wire logic [stog_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [stog_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               restart,

    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic      [stog_pkg::COORD_W-1:0]       rect_left,
    output logic      [stog_pkg::COORD_W-1:0]       rect_top,
    output logic      [stog_pkg::COORD_W-1:0]       rect_right,
    output logic      [stog_pkg::COORD_W-1:0]       rect_bottom,
    output logic                                    last_tile
);

    // room for one step past either end of the grid
    localparam int POS_W = TILE_INDEX_BITS + 2;

    typedef enum logic [1:0] {
        HEAD_RIGHT = 2'd0,
        HEAD_UP    = 2'd1,
        HEAD_LEFT  = 2'd2,
        HEAD_DOWN  = 2'd3
    } heading_t;

    logic [stog_pkg::SIZE_W-1:0]   tile_size_reg;
    logic [TILE_INDEX_BITS-1:0]    last_row_reg;
    logic [TILE_INDEX_BITS-1:0]    last_col_reg;
    logic [stog_pkg::ORIGIN_W-1:0] origin_x_reg;
    logic [stog_pkg::ORIGIN_W-1:0] origin_y_reg;

    logic signed [POS_W-1:0] cur_row_reg, cur_col_reg;
    logic signed [POS_W-1:0] bound_top_reg, bound_bottom_reg;
    logic signed [POS_W-1:0] bound_left_reg, bound_right_reg;
    heading_t                heading_reg;
    logic                    active_reg;

    logic signed [POS_W-1:0] cur_row_next, cur_col_next;
    logic signed [POS_W-1:0] bound_top_next, bound_bottom_next;
    logic signed [POS_W-1:0] bound_left_next, bound_right_next;
    heading_t                heading_next;
    logic                    active_next;

    logic signed [POS_W-1:0] row_now, col_now;
    logic signed [POS_W-1:0] top_now, bottom_now, left_now, right_now;
    heading_t                heading_now;
    logic                    active_now;

    logic                    out_valid_reg;
    logic [stog_pkg::COORD_W-1:0] rect_left_reg, rect_top_reg;
    logic [stog_pkg::COORD_W-1:0] rect_right_reg, rect_bottom_reg;
    logic                    last_tile_reg;

    logic [stog_pkg::COORD_W-1:0] x_lo, x_hi, y_lo, y_hi;
    logic                    in_fire;
    logic                    emit;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // restart overrides the walk state for this beat
    always_comb
    begin
        if (restart)
        begin
            row_now     = '0;
            col_now     = '0;
            top_now     = '0;
            left_now    = '0;
            bottom_now  = $signed({2'b00, last_row_reg});
            right_now   = $signed({2'b00, last_col_reg});
            heading_now = HEAD_DOWN;
            active_now  = 1'b1;
        end
        else
        begin
            row_now     = cur_row_reg;
            col_now     = cur_col_reg;
            top_now     = bound_top_reg;
            left_now    = bound_left_reg;
            bottom_now  = bound_bottom_reg;
            right_now   = bound_right_reg;
            heading_now = heading_reg;
            active_now  = active_reg;
        end
    end

    // one step of the walk: turn and pull in the finished bound at an edge
    always_comb
    begin
        cur_row_next      = row_now;
        cur_col_next      = col_now;
        bound_top_next    = top_now;
        bound_bottom_next = bottom_now;
        bound_left_next   = left_now;
        bound_right_next  = right_now;
        heading_next      = heading_now;
        unique case (heading_now)
            HEAD_RIGHT:
            begin
                if (col_now == right_now)
                begin
                    bound_bottom_next = bottom_now - POS_W'(1);
                    heading_next      = HEAD_UP;
                    cur_row_next      = row_now - POS_W'(1);
                end
                else
                begin
                    cur_col_next = col_now + POS_W'(1);
                end
            end
            HEAD_UP:
            begin
                if (row_now == top_now)
                begin
                    bound_right_next = right_now - POS_W'(1);
                    heading_next     = HEAD_LEFT;
                    cur_col_next     = col_now - POS_W'(1);
                end
                else
                begin
                    cur_row_next = row_now - POS_W'(1);
                end
            end
            HEAD_LEFT:
            begin
                if (col_now == left_now)
                begin
                    bound_top_next = top_now + POS_W'(1);
                    heading_next   = HEAD_DOWN;
                    cur_row_next   = row_now + POS_W'(1);
                end
                else
                begin
                    cur_col_next = col_now - POS_W'(1);
                end
            end
            default:
            begin
                if (row_now == bottom_now)
                begin
                    bound_left_next = left_now + POS_W'(1);
                    heading_next    = HEAD_RIGHT;
                    cur_col_next    = col_now + POS_W'(1);
                end
                else
                begin
                    cur_row_next = row_now + POS_W'(1);
                end
            end
        endcase
        active_next = (bound_top_next <= bound_bottom_next) &&
                      (bound_left_next <= bound_right_next);
    end

    assign emit = in_fire && active_now;

    // while active the current tile is inside the grid, so the low bits are the index
    stog_rect #(
        .IDX_W (TILE_INDEX_BITS)
    ) u_rect_x (
        .idx       (col_now[TILE_INDEX_BITS-1:0]),
        .tile_size (tile_size_reg),
        .origin    (origin_x_reg),
        .lo        (x_lo),
        .hi        (x_hi)
    );

    stog_rect #(
        .IDX_W (TILE_INDEX_BITS)
    ) u_rect_y (
        .idx       (row_now[TILE_INDEX_BITS-1:0]),
        .tile_size (tile_size_reg),
        .origin    (origin_y_reg),
        .lo        (y_lo),
        .hi        (y_hi)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_size_reg <= stog_pkg::TILE_SIZE_RESET;
            last_row_reg  <= TILE_INDEX_BITS'(stog_pkg::LAST_ROW_RESET);
            last_col_reg  <= TILE_INDEX_BITS'(stog_pkg::LAST_COL_RESET);
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                stog_pkg::REG_TILE_SIZE: tile_size_reg <= cfg_wdata;
                stog_pkg::REG_LAST_ROW:  last_row_reg  <= cfg_wdata[TILE_INDEX_BITS-1:0];
                stog_pkg::REG_LAST_COL:  last_col_reg  <= cfg_wdata[TILE_INDEX_BITS-1:0];
                stog_pkg::REG_ORIGIN_X:  origin_x_reg  <= cfg_wdata;
                stog_pkg::REG_ORIGIN_Y:  origin_y_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg      <= '0;
            cur_col_reg      <= '0;
            bound_top_reg    <= '0;
            bound_bottom_reg <= '0;
            bound_left_reg   <= '0;
            bound_right_reg  <= '0;
            heading_reg      <= HEAD_DOWN;
            active_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                cur_row_reg      <= cur_row_next;
                cur_col_reg      <= cur_col_next;
                bound_top_reg    <= bound_top_next;
                bound_bottom_reg <= bound_bottom_next;
                bound_left_reg   <= bound_left_next;
                bound_right_reg  <= bound_right_next;
                heading_reg      <= heading_next;
                active_reg       <= active_next;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            rect_left_reg   <= x_lo;
            rect_right_reg  <= x_hi;
            rect_top_reg    <= y_lo;
            rect_bottom_reg <= y_hi;
            last_tile_reg   <= !active_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign rect_left   = rect_left_reg;
    assign rect_top    = rect_top_reg;
    assign rect_right  = rect_right_reg;
    assign rect_bottom = rect_bottom_reg;
    assign last_tile   = last_tile_reg;

endmodule

`default_nettype wire

FILE: tb/sv/tb_spiral_tile_order_generator.sv
// testbench for the spiral tile order generator: random handshakes, spiral predictor, checker
`timescale 1ns / 100ps

module tb_spiral_tile_order_generator;

    localparam int TILE_INDEX_BITS = 8;
    localparam int IDX_MASK        = (1 << TILE_INDEX_BITS) - 1;
    localparam int DRAIN_CYCLES    = 4;
    localparam int RUN_LIMIT_NS    = 2_000_000;

    typedef enum logic [1:0] {
        HEAD_RIGHT = 2'd0,
        HEAD_UP    = 2'd1,
        HEAD_LEFT  = 2'd2,
        HEAD_DOWN  = 2'd3
    } heading_t;

    typedef enum int {
        BEAT_TICK,
        BEAT_RESTART,
        BEAT_RANDOM
    } beat_kind_t;

    typedef struct {
        logic [stog_pkg::COORD_W-1:0] left;
        logic [stog_pkg::COORD_W-1:0] top;
        logic [stog_pkg::COORD_W-1:0] right;
        logic [stog_pkg::COORD_W-1:0] bottom;
        logic                         last;
    } tile_rect_t;

    class tile_rect_scoreboard;
        logic [stog_pkg::SIZE_W-1:0]   tile_size;
        logic [7:0]                    last_row;
        logic [7:0]                    last_col;
        logic [stog_pkg::ORIGIN_W-1:0] origin_x;
        logic [stog_pkg::ORIGIN_W-1:0] origin_y;

        logic signed [8:0]   cur_row;
        logic signed [8:0]   cur_col;
        logic signed [8:0]   bound_top;
        logic signed [8:0]   bound_bottom;
        logic signed [8:0]   bound_left;
        logic signed [8:0]   bound_right;
        heading_t            heading;
        bit                  walking;

        tile_rect_t          expected_tiles[$];
        int                  tiles_predicted;
        int                  errors;

        function new();
            tile_size       = stog_pkg::TILE_SIZE_RESET;
            last_row        = 8'(stog_pkg::LAST_ROW_RESET & IDX_MASK);
            last_col        = 8'(stog_pkg::LAST_COL_RESET & IDX_MASK);
            origin_x        = '0;
            origin_y        = '0;
            cur_row         = '0;
            cur_col         = '0;
            bound_top       = '0;
            bound_bottom    = '0;
            bound_left      = '0;
            bound_right     = '0;
            heading         = HEAD_DOWN;
            walking         = 1'b0;
            tiles_predicted = 0;
            errors          = 0;
        endfunction

        function void apply_reg(logic [stog_pkg::CFG_ADDR_W-1:0] idx,
                                logic [stog_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                stog_pkg::REG_TILE_SIZE: tile_size = val;
                stog_pkg::REG_LAST_ROW:  last_row  = 8'(val & IDX_MASK);
                stog_pkg::REG_LAST_COL:  last_col  = 8'(val & IDX_MASK);
                stog_pkg::REG_ORIGIN_X:  origin_x  = val;
                stog_pkg::REG_ORIGIN_Y:  origin_y  = val;
                default: ;
            endcase
        endfunction

        // one step of the walk: turn counter-clockwise at a bound and pull that bound in
        function void step_walk();
            case (heading)
                HEAD_RIGHT:
                    if (cur_col == bound_right)
                    begin
                        bound_bottom--;
                        heading = HEAD_UP;
                        cur_row--;
                    end
                    else
                        cur_col++;
                HEAD_UP:
                    if (cur_row == bound_top)
                    begin
                        bound_right--;
                        heading = HEAD_LEFT;
                        cur_col--;
                    end
                    else
                        cur_row--;
                HEAD_LEFT:
                    if (cur_col == bound_left)
                    begin
                        bound_top++;
                        heading = HEAD_DOWN;
                        cur_row++;
                    end
                    else
                        cur_col--;
                default:
                    if (cur_row == bound_bottom)
                    begin
                        bound_left++;
                        heading = HEAD_RIGHT;
                        cur_col++;
                    end
                    else
                        cur_row++;
            endcase
            walking = (bound_top <= bound_bottom) && (bound_left <= bound_right);
        endfunction

        function void note_beat(logic restart_bit);
            tile_rect_t                   want;
            logic [stog_pkg::COORD_W-1:0] col_ext;
            logic [stog_pkg::COORD_W-1:0] row_ext;
            if (restart_bit)
            begin
                bound_top    = '0;
                bound_left   = '0;
                bound_bottom = {1'b0, last_row};
                bound_right  = {1'b0, last_col};
                cur_row      = '0;
                cur_col      = '0;
                heading      = HEAD_DOWN;
                walking      = 1'b1;
            end
            if (!walking)
                return;
            col_ext     = {{(stog_pkg::COORD_W-9){cur_col[8]}}, cur_col};
            row_ext     = {{(stog_pkg::COORD_W-9){cur_row[8]}}, cur_row};
            want.left   = col_ext * tile_size + origin_x;
            want.top    = row_ext * tile_size + origin_y;
            want.right  = want.left + tile_size;
            want.bottom = want.top + tile_size;
            step_walk();
            want.last   = !walking;
            expected_tiles.push_back(want);
            tiles_predicted++;
        endfunction

        function void check_field(string name, logic [stog_pkg::COORD_W-1:0] want,
                                  logic [stog_pkg::COORD_W-1:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_rect(logic [stog_pkg::COORD_W-1:0] l,
                                 logic [stog_pkg::COORD_W-1:0] t,
                                 logic [stog_pkg::COORD_W-1:0] r,
                                 logic [stog_pkg::COORD_W-1:0] b, logic lst);
            tile_rect_t want;
            if (expected_tiles.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected tile: expected none, got left %0d top %0d",
                         $time, l, t);
                return;
            end
            want = expected_tiles.pop_front();
            check_field("rect_left", want.left, l);
            check_field("rect_top", want.top, t);
            check_field("rect_right", want.right, r);
            check_field("rect_bottom", want.bottom, b);
            check_field("last_tile", stog_pkg::COORD_W'(want.last), stog_pkg::COORD_W'(lst));
        endfunction

        function int pending();
            return expected_tiles.size();
        endfunction
    endclass

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [stog_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [stog_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    logic                            restart   = 1'b0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [stog_pkg::COORD_W-1:0]    rect_left;
    logic [stog_pkg::COORD_W-1:0]    rect_top;
    logic [stog_pkg::COORD_W-1:0]    rect_right;
    logic [stog_pkg::COORD_W-1:0]    rect_bottom;
    logic                            last_tile;

    tile_rect_scoreboard   sb = new();
    int                    burst_left = 0;
    int unsigned           stall_cyc  = 0;

    spiral_tile_order_generator #(
        .TILE_INDEX_BITS (TILE_INDEX_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .rect_left   (rect_left),
        .rect_top    (rect_top),
        .rect_right  (rect_right),
        .rect_bottom (rect_bottom),
        .last_tile   (last_tile)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                sb.apply_reg(cfg_addr, cfg_wdata);
            if (in_valid && in_ready)
                sb.note_beat(restart);
            if (out_valid && out_ready)
                sb.check_rect(rect_left, rect_top, rect_right, rect_bottom, last_tile);
        end
    end

    // receiver stall pattern: always ready, mostly ready, periodic, coin flip
    always @(negedge clk)
    begin
        stall_cyc++;
        case (stall_cyc[9:8])
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
            2'd2:    out_ready <= (stall_cyc[2:0] >= 3'd3);
            default: out_ready <= 1'($urandom_range(0, 1));
        endcase
    end

    function automatic logic pick_restart(beat_kind_t kind);
        case (kind)
            BEAT_TICK:    return 1'b0;
            BEAT_RESTART: return 1'b1;
            default:      return sb.walking ? ($urandom_range(0, 49) == 0)
                                            : ($urandom_range(0, 4) != 0);
        endcase
    endfunction

    task automatic send_beat(input beat_kind_t kind);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        // restart is chosen here so the walk state already holds the previous beat
        in_valid <= 1'b1;
        restart  <= pick_restart(kind);
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
    endtask

    task automatic wait_drained(input int extra);
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [stog_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [stog_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_grid(input logic [stog_pkg::CFG_DATA_W-1:0] ts,
                            input logic [stog_pkg::CFG_DATA_W-1:0] lr,
                            input logic [stog_pkg::CFG_DATA_W-1:0] lc,
                            input logic [stog_pkg::CFG_DATA_W-1:0] ox,
                            input logic [stog_pkg::CFG_DATA_W-1:0] oy);
        wait_drained(DRAIN_CYCLES);
        write_cfg(stog_pkg::REG_TILE_SIZE, ts);
        write_cfg(stog_pkg::REG_LAST_ROW, lr);
        write_cfg(stog_pkg::REG_LAST_COL, lc);
        write_cfg(stog_pkg::REG_ORIGIN_X, ox);
        write_cfg(stog_pkg::REG_ORIGIN_Y, oy);
    endtask

    function automatic logic [stog_pkg::CFG_DATA_W-1:0] pick_coord();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            default: return stog_pkg::CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [stog_pkg::CFG_DATA_W-1:0] pick_index();
        logic [7:0] idx;
        case ($urandom_range(0, 9))
            0:       idx = 8'd0;
            1:       idx = 8'd255;
            default: idx = 8'($urandom_range(0, 7));
        endcase
        // junk in the upper bits must be dropped by the block
        return {4'($urandom), idx};
    endfunction

    task automatic run_random_phase(input int quota);
        int goal;
        bit paused;
        logic [stog_pkg::CFG_DATA_W-1:0] ts;
        case ($urandom_range(0, 5))
            0:       ts = '0;
            1:       ts = '1;
            2:       ts = 12'd1;
            default: ts = stog_pkg::CFG_DATA_W'($urandom_range(1, 4095));
        endcase
        set_grid(ts, pick_index(), pick_index(), pick_coord(), pick_coord());
        goal   = sb.tiles_predicted + quota;
        paused = 1'b0;
        while (sb.tiles_predicted < goal)
        begin
            // hold the sender once mid-phase until every tile is out
            if (!paused && sb.tiles_predicted >= goal - quota / 2)
            begin
                wait_drained(0);
                paused = 1'b1;
            end
            send_beat(BEAT_RANDOM);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ticks before any restart give nothing
        send_beat(BEAT_TICK);
        send_beat(BEAT_TICK);
        // register values after reset
        send_beat(BEAT_RESTART);
        repeat (3) send_beat(BEAT_TICK);
        // restart in the middle of a spiral
        send_beat(BEAT_RESTART);
        send_beat(BEAT_TICK);

        // single tile, zero tile size, origin at its top
        set_grid(12'd0, 12'd0, 12'd0, 12'hFFF, 12'hFFF);
        send_beat(BEAT_RESTART);
        send_beat(BEAT_TICK);

        // largest grid and tile, index registers given all ones
        set_grid(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        send_beat(BEAT_RESTART);
        repeat (4) send_beat(BEAT_TICK);

        // one row: the bottom bound is pulled in past zero
        set_grid(12'd5, 12'd0, 12'd2, 12'd7, 12'd3);
        send_beat(BEAT_RESTART);
        repeat (4) send_beat(BEAT_TICK);

        repeat (12) run_random_phase(34);

        wait_drained(DRAIN_CYCLES);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("%0t: timeout with %0d tile(s) still expected", $time, sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
src/stog_pkg.sv
src/stog_rect.sv
src/spiral_tile_order_generator.sv
tb/sv/tb_spiral_tile_order_generator.sv
